FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked only while out of reset.
`define ABF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define ABF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ABF_ASSERT(name, prop, msg)
`define ABF_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

FILE: rtl/core/abf_pkg.sv
// Types, constants and codes shared by the aging Bloom filter modules.
package abf_pkg;

  localparam int GENERATIONS   = 16;
  localparam int PROBES        = 8;
  localparam int INDEX_BITS    = 16;
  localparam int SELECTORS     = 2;

  localparam int SLICE_W       = 16;
  localparam int ID_W          = 128;
  localparam int BITS_PER_WORD = 16;
  localparam int BIT_SEL_W     = $clog2(BITS_PER_WORD);
  localparam int WORD_W        = INDEX_BITS - BIT_SEL_W;
  localparam int PROBE_W       = $clog2(PROBES);
  localparam int SEL_W         = (SELECTORS > 1) ? $clog2(SELECTORS) : 1;
  localparam int SLOT_W        = $clog2(GENERATIONS);
  localparam int ROW_W         = SEL_W + PROBE_W + WORD_W;
  localparam int ROWS          = 2 ** ROW_W;
  localparam int CNT_W         = $clog2(PROBES + 1);

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_INSERT  = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_LOOKUP,
    CMD_INSERT,
    CMD_ADVANCE
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_INS,
    ST_ADV
  } st_e;

  typedef struct packed {
    opcode_e     opcode;
    logic        filter_sel;
    logic [63:0] id_high;
    logic [63:0] id_low;
  } in_item_t;

  typedef struct packed {
    logic    found;
    opcode_e done_op;
  } out_item_t;

  typedef logic [PROBES-1:0][INDEX_BITS-1:0] pos_t;

  // One memory row: the same probe word of every generation slot.
  typedef logic [GENERATIONS-1:0][BITS_PER_WORD-1:0] row_t;

  typedef struct packed {
    cmd_e             kind;
    opcode_e          op;
    logic [SEL_W-1:0] sel;
    pos_t             pos;
  } cmd_t;

  typedef struct packed {
    logic                   rd_en;
    logic [ROW_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [ROW_W-1:0]       wr_addr;
    logic [GENERATIONS-1:0] wr_seg_en;
    row_t                   wr_data;
  } mem_req_t;

endpackage

FILE: rtl/core/aging_bloom_filter.sv
// Top level of the aging Bloom filter: front end, command queue and back end.
//
//   channel | dir | handshake                     | payload
//   in      | in  | in_valid_i / in_ready_o       | in_item_i  (abf_pkg::in_item_t)
//   out     | out | out_valid_o / out_ready_i     | out_item_o (abf_pkg::out_item_t)
//
// A lookup or insert picks up the command, then makes eight row reads through the single
// read port of the store, the last compare or write overlapping the final read return.
// Opcode 3 and absent filters complete straight from the idle state with no store access.
// An advance zeroes the new generation 0 slot row by row.
// After reset the store is swept clear row by row; items queue up meanwhile.
// The back end starts a command only while the result register is empty; the front end
// and queue keep taking transfers while a result waits.
module aging_bloom_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  abf_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output abf_pkg::out_item_t out_item_o
);

  logic          f_valid, f_ready;
  abf_pkg::cmd_t f_cmd;
  logic          q_valid, q_ready;
  abf_pkg::cmd_t q_cmd;

  abf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  abf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  abf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_cmd_i     (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: rtl/core/abf_front.sv
// Front end: accepts input items, decodes them and cuts the identifier into probe positions.
module abf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  abf_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output abf_pkg::cmd_t     cmd_o
);

  logic                        valid_q, valid_d;
  abf_pkg::cmd_t               cmd_q, cmd_d;
  logic                        load;
  logic                        sel_ok;
  logic [abf_pkg::ID_W-1:0]    id;
  logic [abf_pkg::SLICE_W-1:0] slice;

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign sel_ok     = int'(in_item_i.filter_sel) < abf_pkg::SELECTORS;
  assign id         = {in_item_i.id_high, in_item_i.id_low};

  always_comb begin
    cmd_d     = cmd_q;
    slice     = '0;
    if (load) begin
      cmd_d.op  = in_item_i.opcode;
      cmd_d.sel = abf_pkg::SEL_W'(in_item_i.filter_sel);
      case (in_item_i.opcode)
        abf_pkg::OP_LOOKUP:  cmd_d.kind = sel_ok ? abf_pkg::CMD_LOOKUP : abf_pkg::CMD_NOP;
        abf_pkg::OP_INSERT:  cmd_d.kind = sel_ok ? abf_pkg::CMD_INSERT : abf_pkg::CMD_NOP;
        abf_pkg::OP_ADVANCE: cmd_d.kind = abf_pkg::CMD_ADVANCE;
        default:             cmd_d.kind = abf_pkg::CMD_NOP;
      endcase
      // Slice 0 is the most significant 16 bits of the identifier.
      for (int k = 0; k < abf_pkg::PROBES; k++) begin
        slice        = id[abf_pkg::ID_W-1-abf_pkg::SLICE_W*k -: abf_pkg::SLICE_W];
        cmd_d.pos[k] = slice[abf_pkg::INDEX_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

FILE: rtl/core/abf_queue.sv
// Short command queue between the front end and the back end.
`include "assert_macros.svh"

module abf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  abf_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output abf_pkg::cmd_t pop_cmd_o
);

  abf_pkg::cmd_t               entries_q [abf_pkg::QUEUE_DEPTH];
  logic [abf_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [abf_pkg::QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [abf_pkg::QCNT_W-1:0]  count_q, count_d;
  logic                        push, pop;

  assign push_ready_o = count_q < abf_pkg::QCNT_W'(abf_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == abf_pkg::QPTR_W'(abf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == abf_pkg::QPTR_W'(abf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `ABF_ASSERT(a_queue_count_bound, count_q <= abf_pkg::QCNT_W'(abf_pkg::QUEUE_DEPTH), "queue count exceeds depth")

endmodule

FILE: rtl/core/abf_store.sv
// Filter memory: one row per selector, probe and word, one segment per generation slot.
module abf_store (
  input  logic              clk_i,
  input  abf_pkg::mem_req_t req_i,
  output abf_pkg::row_t     rd_data_o
);

  abf_pkg::row_t mem [abf_pkg::ROWS];
  abf_pkg::row_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      for (int g = 0; g < abf_pkg::GENERATIONS; g++) begin
        if (req_i.wr_seg_en[g]) begin
          mem[req_i.wr_addr][g] <= req_i.wr_data[g];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/abf_back.sv
// Back end: sequences lookups, inserts, generation advances and the reset clear over the store.
`include "assert_macros.svh"

module abf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  abf_pkg::cmd_t      q_cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output abf_pkg::out_item_t out_item_o
);

  abf_pkg::st_e                  state_q, state_d;
  abf_pkg::cmd_t                 cmd_q, cmd_d;
  logic [abf_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [abf_pkg::ROW_W-1:0]     row_q, row_d;
  logic [abf_pkg::SLOT_W-1:0]    head_q, head_d;
  logic [abf_pkg::GENERATIONS-1:0] acc_q, acc_d;
  logic                          rd_vld_q, rd_vld_d;
  logic [abf_pkg::BIT_SEL_W-1:0] bitsel_q, bitsel_d;
  logic [abf_pkg::ROW_W-1:0]     wr_row_q, wr_row_d;
  logic                          out_valid_q, out_valid_d;
  abf_pkg::out_item_t            out_item_q, out_item_d;

  abf_pkg::mem_req_t             mem_req;
  abf_pkg::row_t                 rd_data;
  logic [abf_pkg::GENERATIONS-1:0] rd_bits;
  logic [abf_pkg::INDEX_BITS-1:0]  cur_pos;
  logic                          q_pop;
  logic                          res_load;
  abf_pkg::out_item_t            res_item;
  logic                          adv_start;
  logic                          probes_done;
  logic                          row_last;

  // Picks the addressed bit of every generation slot out of one row.
  function automatic logic [abf_pkg::GENERATIONS-1:0] slot_bits(
    abf_pkg::row_t row, logic [abf_pkg::BIT_SEL_W-1:0] bsel);
    logic [abf_pkg::GENERATIONS-1:0] bits;
    for (int g = 0; g < abf_pkg::GENERATIONS; g++) begin
      bits[g] = row[g][bsel];
    end
    return bits;
  endfunction

  abf_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  assign rd_bits     = slot_bits(rd_data, bitsel_q);
  assign cur_pos     = cmd_q.pos[cnt_q[abf_pkg::PROBE_W-1:0]];
  assign q_pop       = (state_q == abf_pkg::ST_IDLE) && q_valid_i && !out_valid_q;
  assign q_ready_o   = q_pop;
  assign adv_start   = q_pop && (q_cmd_i.kind == abf_pkg::CMD_ADVANCE);
  assign probes_done = cnt_q == abf_pkg::CNT_W'(abf_pkg::PROBES);
  assign row_last    = row_q == '1;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      abf_pkg::ST_CLEAR: begin
        if (row_last) begin
          state_d = abf_pkg::ST_IDLE;
        end
      end
      abf_pkg::ST_IDLE: begin
        if (q_pop) begin
          case (q_cmd_i.kind)
            abf_pkg::CMD_LOOKUP:  state_d = abf_pkg::ST_LOOK;
            abf_pkg::CMD_INSERT:  state_d = abf_pkg::ST_INS;
            abf_pkg::CMD_ADVANCE: state_d = abf_pkg::ST_ADV;
            default:              state_d = abf_pkg::ST_IDLE;
          endcase
        end
      end
      abf_pkg::ST_LOOK, abf_pkg::ST_INS: begin
        if (probes_done) begin
          state_d = abf_pkg::ST_IDLE;
        end
      end
      abf_pkg::ST_ADV: begin
        if (row_last) begin
          state_d = abf_pkg::ST_IDLE;
        end
      end
      default: state_d = abf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    mem_req  = '0;
    cmd_d    = cmd_q;
    cnt_d    = cnt_q;
    row_d    = row_q;
    head_d   = head_q;
    acc_d    = acc_q;
    rd_vld_d = 1'b0;
    bitsel_d = bitsel_q;
    wr_row_d = wr_row_q;
    res_load = 1'b0;
    res_item = '0;
    case (state_q)
      abf_pkg::ST_CLEAR: begin
        mem_req.wr_en     = 1'b1;
        mem_req.wr_addr   = row_q;
        mem_req.wr_seg_en = '1;
        row_d             = row_q + 1'b1;
      end
      abf_pkg::ST_IDLE: begin
        if (q_pop) begin
          cmd_d = q_cmd_i;
          cnt_d = '0;
          row_d = '0;
          acc_d = '1;
          if (q_cmd_i.kind == abf_pkg::CMD_ADVANCE) begin
            // Generation g lives in slot (head + g) mod GENERATIONS, so aging moves head down.
            head_d = (head_q == '0) ? abf_pkg::SLOT_W'(abf_pkg::GENERATIONS - 1)
                                    : head_q - 1'b1;
          end
          if (q_cmd_i.kind == abf_pkg::CMD_NOP) begin
            res_load         = 1'b1;
            res_item.done_op = q_cmd_i.op;
          end
        end
      end
      abf_pkg::ST_LOOK, abf_pkg::ST_INS: begin
        if (!probes_done) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = {cmd_q.sel, cnt_q[abf_pkg::PROBE_W-1:0],
                             cur_pos[abf_pkg::INDEX_BITS-1:abf_pkg::BIT_SEL_W]};
          rd_vld_d        = 1'b1;
          bitsel_d        = cur_pos[abf_pkg::BIT_SEL_W-1:0];
          wr_row_d        = mem_req.rd_addr;
          cnt_d           = cnt_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (state_q == abf_pkg::ST_LOOK) begin
            acc_d = acc_q & rd_bits;
          end else begin
            // Read-modify-write of the generation 0 segment only.
            mem_req.wr_en           = 1'b1;
            mem_req.wr_addr         = wr_row_q;
            mem_req.wr_seg_en[head_q] = 1'b1;
            for (int g = 0; g < abf_pkg::GENERATIONS; g++) begin
              mem_req.wr_data[g] = rd_data[head_q];
            end
            mem_req.wr_data[head_q][bitsel_q] = 1'b1;
          end
        end
        if (probes_done) begin
          res_load         = 1'b1;
          res_item.found   = (state_q == abf_pkg::ST_LOOK) && |(acc_q & rd_bits);
          res_item.done_op = cmd_q.op;
        end
      end
      abf_pkg::ST_ADV: begin
        mem_req.wr_en             = 1'b1;
        mem_req.wr_addr           = row_q;
        mem_req.wr_seg_en[head_q] = 1'b1;
        row_d                     = row_q + 1'b1;
        if (row_last) begin
          res_load         = 1'b1;
          res_item.done_op = cmd_q.op;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_item_d = out_item_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      out_item_d  = res_item;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abf_pkg::ST_CLEAR;
      cnt_q       <= '0;
      row_q       <= '0;
      head_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      head_q      <= head_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    acc_q      <= acc_d;
    bitsel_q   <= bitsel_d;
    wr_row_q   <= wr_row_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ABF_ASSERT(a_no_write_when_idle, (state_q == abf_pkg::ST_IDLE) |-> !mem_req.wr_en, "store written while idle")
  `ABF_ASSERT(a_head_moves_on_advance, !$stable(head_q) |-> $past(adv_start), "generation head moved without an advance")
  `ABF_ASSERT(a_result_into_empty_reg, res_load |-> !out_valid_q, "result overwrote a pending transfer")

endmodule
